>>> hw/rtl/pdf_pkg.sv
//------------------------------------------------------------------------------
// pdf_pkg
// Types, register indexes and a shared arithmetic helper of the plane dot-fold
// transform.
//------------------------------------------------------------------------------
package pdf_pkg;

   localparam int CfgWidth = 60;
   localparam int NumCfg   = 8;

   typedef enum logic [2:0] {
      CFG_FOLD_NORMAL = 3'd0,
      CFG_ROT_ROW_X   = 3'd1,
      CFG_ROT_ROW_Y   = 3'd2,
      CFG_ROT_ROW_Z   = 3'd3,
      CFG_SCALE_OFF   = 3'd4,
      CFG_WIN_LOW     = 3'd5,
      CFG_WIN_HIGH    = 3'd6,
      CFG_EXTRA_SC    = 3'd7
   } cfg_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] dist_est;
      logic [7:0]         iteration;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_dist_est;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0] fold_normal;
      logic [47:0] rot_x;
      logic [47:0] rot_y;
      logic [47:0] rot_z;
      logic [47:0] scale_off;
      logic [47:0] win_low;
      logic [39:0] win_high;
      logic [59:0] extra_sc;
   } cfg_regs_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

>>> hw/rtl/pdf_mult_stage.sv
//------------------------------------------------------------------------------
// pdf_mult_stage
// One extra multiplier: scales the point by s and the estimate by |s| inside
// its iteration window. One register stage.
//------------------------------------------------------------------------------
module pdf_mult_stage #(
   parameter int IterBits = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                enable,
   input  logic [7:0]          win_start,
   input  logic [7:0]          win_stop,
   input  logic signed [11:0]  factor,
   input  logic                in_valid,
   input  logic [IterBits-1:0] in_iter,
   input  pdf_pkg::rsp_word_type in_word,
   output logic                out_valid,
   output logic [IterBits-1:0] out_iter,
   output pdf_pkg::rsp_word_type out_word
);
   import pdf_pkg::*;

   logic                  valid_ff;
   logic [IterBits-1:0]   iter_ff;
   rsp_word_type          word_ff, word_in;
   logic                  act;
   logic signed [12:0]    mag;
   logic [15:0]           it_w;

   assign it_w = 16'(in_iter);
   assign act  = enable && (it_w >= 16'(win_start)) && (it_w < 16'(win_stop));
   assign mag  = factor[11] ? -13'(factor) : 13'(factor);

   always_comb begin
      word_in = in_word;
      if (act) begin
         word_in.out_x = sat32((64'(in_word.out_x) * 64'(factor)) >>> 8);
         word_in.out_y = sat32((64'(in_word.out_y) * 64'(factor)) >>> 8);
         word_in.out_z = sat32((64'(in_word.out_z) * 64'(factor)) >>> 8);
         word_in.out_dist_est = sat32((64'(in_word.out_dist_est) * 64'(mag)) >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         word_ff <= word_in;
         iter_ff <= in_iter;
      end
   end

   assign out_valid = valid_ff;
   assign out_iter  = iter_ff;
   assign out_word  = word_ff;
endmodule

>>> hw/rtl/plane_dot_fold_transform.sv
//------------------------------------------------------------------------------
// plane_dot_fold_transform
// Abs, plane fold, scale/offset, 3x3 rotation and five windowed multipliers.
//------------------------------------------------------------------------------
// A word passes stages s0 to s12 from req accept to rsp valid.
// Throughput: one word per cycle; a stall freezes the whole pipeline.
// The rsp register is the last stage; req_ready = rsp_ready || !rsp_valid.
// Reset: synchronous, clears valid bits and loads register reset values.
module plane_dot_fold_transform #(
   parameter int ITERATION_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pdf_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pdf_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [pdf_pkg::CfgWidth-1:0] csr_data
);
   import pdf_pkg::*;

   localparam int IB = ITERATION_BITS;
   localparam int NS = 8;

   cfg_regs_type cfg_ff;
   logic advance;
   logic [NS-1:0] v_ff;
   logic [IB-1:0] it_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fold_normal <= '0;
         cfg_ff.rot_x       <= 48'd16384;
         cfg_ff.rot_y       <= 48'd1073741824;
         cfg_ff.rot_z       <= 48'd70368744177664;
         cfg_ff.scale_off   <= 48'd4096;
         cfg_ff.win_low     <= '0;
         cfg_ff.win_high    <= '0;
         cfg_ff.extra_sc    <= '0;
      end else if (csr_write) begin
         case (cfg_index_type'(csr_index))
            CFG_FOLD_NORMAL: cfg_ff.fold_normal <= csr_data[47:0];
            CFG_ROT_ROW_X:   cfg_ff.rot_x       <= csr_data[47:0];
            CFG_ROT_ROW_Y:   cfg_ff.rot_y       <= csr_data[47:0];
            CFG_ROT_ROW_Z:   cfg_ff.rot_z       <= csr_data[47:0];
            CFG_SCALE_OFF:   cfg_ff.scale_off   <= csr_data[47:0];
            CFG_WIN_LOW:     cfg_ff.win_low     <= csr_data[47:0];
            CFG_WIN_HIGH:    cfg_ff.win_high    <= csr_data[39:0];
            CFG_EXTRA_SC:    cfg_ff.extra_sc    <= csr_data[59:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] nv [3];
   logic signed [15:0] m [3][3];
   logic signed [15:0] sc;
   logic signed [31:0] off;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nv[k]   = cfg_ff.fold_normal[16*k +: 16];
         m[0][k] = cfg_ff.rot_x[16*k +: 16];
         m[1][k] = cfg_ff.rot_y[16*k +: 16];
         m[2][k] = cfg_ff.rot_z[16*k +: 16];
      end
      sc  = cfg_ff.scale_off[15:0];
      off = cfg_ff.scale_off[47:16];
   end

   assign advance   = rsp_ready || !rsp_valid;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
      if (advance) begin
         it_ff[0] <= IB'(req_word.iteration);
         for (int s = 1; s < NS; s++) it_ff[s] <= it_ff[s-1];
      end
   end

   // s0: abs
   logic signed [31:0] p0_ff [3];
   logic signed [31:0] d0_ff;
   logic signed [31:0] pin [3];
   assign pin[0] = req_word.pos_x;
   assign pin[1] = req_word.pos_y;
   assign pin[2] = req_word.pos_z;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++)
            p0_ff[k] <= (cfg_ff.win_high[32+k] && pin[k] < 0) ?
                        sat32(-64'(pin[k])) : pin[k];
         d0_ff <= req_word.dist_est;
      end
   end

   // s1: dot products
   logic signed [47:0] pr1_ff [3];
   logic signed [31:0] p1_ff [3];
   logic signed [31:0] d1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) pr1_ff[k] <= 48'(p0_ff[k]) * 48'(nv[k]);
         p1_ff <= p0_ff;
         d1_ff <= d0_ff;
      end
   end

   // s2: t
   logic signed [35:0] t2_ff;
   logic signed [31:0] p2_ff [3];
   logic signed [31:0] d2_ff;
   logic signed [49:0] dsum;
   assign dsum = 50'(pr1_ff[0]) + 50'(pr1_ff[1]) + 50'(pr1_ff[2]);
   always_ff @(posedge clock) begin
      if (advance) begin
         t2_ff <= 36'(dsum >>> 14);
         p2_ff <= p1_ff;
         d2_ff <= d1_ff;
      end
   end

   // s3: 2*t*n
   logic signed [52:0] f3_ff [3];
   logic               t3_ff;
   logic signed [31:0] p3_ff [3];
   logic signed [31:0] d3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) f3_ff[k] <= 53'(t2_ff) * 53'(nv[k]) * 53'sd2;
         t3_ff <= t2_ff > 0;
         p3_ff <= p2_ff;
         d3_ff <= d2_ff;
      end
   end

   // s4: fold subtract
   logic signed [31:0] p4_ff [3];
   logic signed [31:0] d4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++)
            p4_ff[k] <= t3_ff ? sat32(64'(p3_ff[k]) - 64'(f3_ff[k] >>> 14)) : p3_ff[k];
         d4_ff <= d3_ff;
      end
   end

   // s5: scale
   logic signed [31:0] p5_ff [3];
   logic signed [31:0] d5_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++)
            p5_ff[k] <= sat32((64'(p4_ff[k]) * 64'(sc)) >>> 12);
         d5_ff <= sat32((64'(d4_ff) * 64'(sc)) >>> 12);
      end
   end

   // s6: offset, rotation products
   logic signed [47:0] rp6_ff [3][3];
   logic signed [31:0] d6_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               rp6_ff[r][k] <= 48'(p5_ff[k]) * 48'(m[r][k]);
         d6_ff <= sat32(64'(d5_ff) + 64'(off));
      end
   end

   // s7: rotation sum
   rsp_word_type w7_ff;
   logic signed [49:0] acc [3];
   always_comb begin
      for (int r = 0; r < 3; r++)
         acc[r] = 50'(rp6_ff[r][0]) + 50'(rp6_ff[r][1]) + 50'(rp6_ff[r][2]);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         w7_ff.out_x        <= sat32(64'(acc[0] >>> 14));
         w7_ff.out_y        <= sat32(64'(acc[1] >>> 14));
         w7_ff.out_z        <= sat32(64'(acc[2] >>> 14));
         w7_ff.out_dist_est <= d6_ff;
      end
   end

   // s8..s12: extra multipliers
   rsp_word_type  mw [6];
   logic          mv [6];
   logic [IB-1:0] mi [6];
   logic [79:0]   wins;
   assign wins  = {cfg_ff.win_high[31:0], cfg_ff.win_low};
   assign mw[0] = w7_ff;
   assign mv[0] = v_ff[NS-1];
   assign mi[0] = it_ff[NS-1];

   for (genvar g = 0; g < 5; g++) begin : g_mult
      pdf_mult_stage #(.IterBits(IB)) u_mult (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .enable    (cfg_ff.win_high[35+g]),
         .win_start (wins[16*g +: 8]),
         .win_stop  (wins[16*g+8 +: 8]),
         .factor    (cfg_ff.extra_sc[12*g +: 12]),
         .in_valid  (mv[g]),
         .in_iter   (mi[g]),
         .in_word   (mw[g]),
         .out_valid (mv[g+1]),
         .out_iter  (mi[g+1]),
         .out_word  (mw[g+1])
      );
   end

   assign rsp_valid = mv[5];
   assign rsp_word  = mw[5];

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled while empty at output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted word lost");
`endif
endmodule
